FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle, off while in reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle, checked during reset too.
`define ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/mhtok_pkg.sv
// ----------------------------------------------------------------------------
// mhtok_pkg
// Shared types and constants of the MIME header tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhtok_pkg;

   // default depth of the front-to-back queue
   localparam int QueueDepth = 4;

   // token codes on the result channel
   typedef enum logic [2:0] {
      TK_KEY        = 3'd0,
      TK_VAL        = 3'd1,
      TK_FIELD_END  = 3'd2,
      TK_HEADER_END = 3'd3,
      TK_ERR_CR     = 3'd4,
      TK_ERR_KEY    = 3'd5
   } tok_kind_type;

   // one classified request: up to two tokens
   typedef struct packed {
      logic [1:0]   tok_cnt;
      tok_kind_type kind0;
      logic [7:0]   byte0;
      tok_kind_type kind1;
      logic [7:0]   byte1;
   } entry_type;

endpackage

FILE: src/mhtok_front.sv
// ----------------------------------------------------------------------------
// mhtok_front
// Accepts header bytes, tracks the parse phase and classifies each request
// into zero, one or two tokens for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhtok_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [7:0]          req_in_byte,
   output logic                full,
   input  logic                q_full,
   output logic                q_push,
   output mhtok_pkg::entry_type q_entry
);
   import mhtok_pkg::*;

   typedef enum logic [2:0] {
      PH_PREKEY = 3'd0,
      PH_KEY    = 3'd1,
      PH_PREVAL = 3'd2,
      PH_VAL    = 3'd3,
      PH_CR     = 3'd4,
      PH_EOL    = 3'd5
   } phase_type;

   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChColon = 8'h3A;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChSpace = 8'h20;

   phase_type  phase_ff, phase_in;
   logic       keyp_ff, keyp_in;
   logic       accept;
   logic       is_ws, is_cr, is_lf, is_colon;
   logic [7:0] low_byte;
   entry_type  ent;

   // A-Z only
   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   assign full     = q_full;
   assign accept   = push && !q_full;
   assign is_ws    = (req_in_byte == ChSpace) || (req_in_byte == ChTab);
   assign is_cr    = (req_in_byte == ChCr);
   assign is_lf    = (req_in_byte == ChLf);
   assign is_colon = (req_in_byte == ChColon);
   assign low_byte = to_lower(req_in_byte);

   // phase transition and token classification
   always_comb begin
      phase_in = phase_ff;
      keyp_in  = keyp_ff;
      ent      = '0;
      unique case (phase_ff)
         PH_CR: begin
            if (is_lf) begin
               phase_in = PH_EOL;
            end else begin
               phase_in    = PH_PREKEY;
               keyp_in     = 1'b0;
               ent.tok_cnt = 2'd1;
               ent.kind0   = TK_ERR_CR;
            end
         end
         PH_EOL: begin
            if (is_ws) begin
               phase_in = PH_VAL;
            end else begin
               // pending field end goes first, then the follow-up token
               if (keyp_ff) begin
                  ent.tok_cnt = 2'd1;
                  ent.kind0   = TK_FIELD_END;
                  keyp_in     = 1'b0;
               end
               if (!is_cr) begin
                  if (is_lf) begin
                     phase_in = PH_PREKEY;
                     keyp_in  = 1'b0;
                     if (keyp_ff) begin
                        ent.kind1 = TK_HEADER_END;
                     end else begin
                        ent.kind0 = TK_HEADER_END;
                     end
                  end else begin
                     phase_in = PH_KEY;
                     keyp_in  = 1'b1;
                     if (keyp_ff) begin
                        ent.kind1 = TK_KEY;
                        ent.byte1 = low_byte;
                     end else begin
                        ent.kind0 = TK_KEY;
                        ent.byte0 = low_byte;
                     end
                  end
                  ent.tok_cnt = keyp_ff ? 2'd2 : 2'd1;
               end
            end
         end
         PH_KEY: begin
            if (!is_ws) begin
               if (is_colon) begin
                  phase_in = PH_PREVAL;
               end else begin
                  ent.tok_cnt = 2'd1;
                  ent.kind0   = TK_KEY;
                  ent.byte0   = low_byte;
               end
            end
         end
         PH_PREVAL: begin
            if (!is_ws) begin
               if (is_cr) begin
                  phase_in = PH_CR;
               end else if (is_lf) begin
                  phase_in = PH_EOL;
               end else begin
                  phase_in    = PH_VAL;
                  ent.tok_cnt = 2'd1;
                  ent.kind0   = TK_VAL;
                  ent.byte0   = req_in_byte;
               end
            end
         end
         PH_VAL: begin
            if (is_cr) begin
               phase_in = PH_CR;
            end else if (is_lf) begin
               phase_in = PH_EOL;
            end else begin
               ent.tok_cnt = 2'd1;
               ent.kind0   = TK_VAL;
               ent.byte0   = req_in_byte;
            end
         end
         default: begin
            // pre-key, and any unused phase code
            if (is_ws) begin
               phase_in = PH_PREKEY;
            end else if (is_colon) begin
               phase_in    = PH_PREKEY;
               keyp_in     = 1'b0;
               ent.tok_cnt = 2'd1;
               ent.kind0   = TK_ERR_KEY;
            end else begin
               phase_in    = PH_KEY;
               keyp_in     = 1'b1;
               ent.tok_cnt = 2'd1;
               ent.kind0   = TK_KEY;
               ent.byte0   = low_byte;
            end
         end
      endcase
   end

   assign q_push  = accept && (ent.tok_cnt != 2'd0);
   assign q_entry = ent;

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREKEY;
         keyp_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         keyp_ff  <= keyp_in;
      end
   end

endmodule

FILE: src/mhtok_queue.sv
// ----------------------------------------------------------------------------
// mhtok_queue
// Short register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhtok_queue #(
   parameter int DEPTH = mhtok_pkg::QueueDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mhtok_pkg::entry_type push_entry,
   output logic                 q_full,
   input  logic                 q_pop,
   output logic                 q_empty,
   output mhtok_pkg::entry_type q_head
);
   import mhtok_pkg::*;

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   entry_type       slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign q_full  = (cnt_ff == FullCnt);
   assign q_empty = (cnt_ff == '0);
   assign q_head  = slot_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/mhtok_back.sv
// ----------------------------------------------------------------------------
// mhtok_back
// Drains queued requests and presents their tokens one at a time in the
// result register, marking the last token of each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhtok_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  mhtok_pkg::entry_type q_head,
   output logic                 q_pop,
   input  logic                 pop,
   output logic                 empty,
   output logic [2:0]           rsp_token_kind,
   output logic [7:0]           rsp_token_byte,
   output logic                 rsp_last_of_run
);
   import mhtok_pkg::*;

   logic         valid_ff, valid_in;
   logic         second_ff, second_in;
   tok_kind_type kind_ff, kind_in;
   logic [7:0]   byte_ff, byte_in;
   logic         last_ff, last_in;
   logic         load;

   // result register free or being taken this cycle
   assign load = !q_empty && (!valid_ff || pop);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      q_pop     = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (second_ff) begin
            kind_in   = q_head.kind1;
            byte_in   = q_head.byte1;
            last_in   = 1'b1;
            second_in = 1'b0;
            q_pop     = 1'b1;
         end else if (q_head.tok_cnt == 2'd2) begin
            kind_in   = q_head.kind0;
            byte_in   = q_head.byte0;
            last_in   = 1'b0;
            second_in = 1'b1;
         end else begin
            kind_in = q_head.kind0;
            byte_in = q_head.byte0;
            last_in = 1'b1;
            q_pop   = 1'b1;
         end
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // result payload, no reset
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign empty           = !valid_ff;
   assign rsp_token_kind  = kind_ff;
   assign rsp_token_byte  = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

FILE: src/mime_header_tokenizer_unit.sv
// An accepted byte's tokens are queued, then moved into the result register.
// Throughput: one byte per cycle while the queue is not full; the single result
// register sends one token per cycle while pop is asserted, so a byte with two
// tokens keeps it busy while the QUEUE_DEPTH-entry queue absorbs the difference.
// Reset: synchronous, active high; clears parse phase, key flag, queue and result.
// ----------------------------------------------------------------------------
// mime_header_tokenizer_unit
// MIME header tokenizer: front classifier, request queue, token output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mime_header_tokenizer_unit #(
   parameter int QUEUE_DEPTH = mhtok_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] req_in_byte,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_last_of_run
);
   import mhtok_pkg::*;

   logic      q_full, q_push, q_empty, q_pop;
   entry_type q_entry, q_head;
   logic      rsp_is_ctl, rsp_is_key;

   // classifier
   mhtok_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_in_byte (req_in_byte),
      .full        (full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   // request queue
   mhtok_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .q_full     (q_full),
      .q_pop      (q_pop),
      .q_empty    (q_empty),
      .q_head     (q_head)
   );

   // token output stage
   mhtok_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // kind of the token on the result ports
   assign rsp_is_ctl = !empty && (rsp_token_kind != TK_KEY) && (rsp_token_kind != TK_VAL);
   assign rsp_is_key = !empty && (rsp_token_kind == TK_KEY);

   // control tokens carry no character
   `ASSERT_IMPL(a_ctl_byte_zero, clock, reset, rsp_is_ctl, rsp_token_byte == 8'h00)
   // key characters are never upper case letters
   `ASSERT_IMPL(a_key_lower, clock, reset, rsp_is_key, (rsp_token_byte < 8'h41) || (rsp_token_byte > 8'h5A))
   // reset empties the result side
   `ASSERT_NEXT(a_reset_empty, clock, reset, empty)

endmodule
